/* design/assert_macros.svh */
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* design/mpfb_pkg.sv */
// ---------------------------------------------------------------------------
// mpfb_pkg
// Shared constants, codes and control structs of the paged framebuffer engine.
// ---------------------------------------------------------------------------
package mpfb_pkg;

  localparam int BUFFER_BYTES = 2048;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int HATCH_PERIOD = 4;
  localparam int HCNT_W       = $clog2(HATCH_PERIOD);
  // page * width + column, wide enough for 63 * 256 + 255 and the store size
  localparam int LOC_W        = 16;

  typedef enum logic [2:0] {
    F_PIXEL   = 3'd0,
    F_FILL    = 3'd1,
    F_HATCH   = 3'd2,
    F_LINE    = 3'd3,
    F_OUTLINE = 3'd4,
    F_READ    = 3'd5,
    F_CLEAR   = 3'd6,
    F_NONE    = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RPB    = 2'd2,
    REG_UNUSED = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic       capture;
    logic       point;
    logic       seg_load;
    logic [1:0] seg;
    logic       outline;
    logic       area;
    logic       hatch;
    logic       div_step;
    logic       pix_rd;
    logic       pix_wr;
    logic       rd_dat;
    logic       clr_init;
    logic       clr_step;
    logic       out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_done;
    logic seg_last;
    logic clr_last;
  } dp_status_t;

endpackage

/* design/mono_page_framebuffer_draw_engine.sv */
// ---------------------------------------------------------------------------
// mono_page_framebuffer_draw_engine
// Drawing engine for a one-bit paged framebuffer: pixel, fill, hatch, line,
// outline, pixel read and clear, one result per command.
// ---------------------------------------------------------------------------
// channel  direction  ports
// in       input      in_func in_xa in_ya in_xb in_yb in_ink
// out      output     out_pixel_value out_clipped
// cfg      input      cfg_index cfg_data
//
// every touched pixel takes a byte read, then a byte write, on the single
// frame store; each line, edge or rectangle adds a load and a page division.
// clear sweeps 2048 bytes, one a cycle; the same sweep runs after reset with
// in_ready low. one command is in flight at a time; a finished command holds
// in its last cycle while the previous result still waits on out_ready.
// ---------------------------------------------------------------------------
module mono_page_framebuffer_draw_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_func,
  input  logic [7:0] in_xa,
  input  logic [7:0] in_ya,
  input  logic [7:0] in_xb,
  input  logic [7:0] in_yb,
  input  logic       in_ink,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_pixel_value,
  output logic       out_clipped,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);
  import mpfb_pkg::*;
  `include "assert_macros.svh"

  ctl_cmd_t   cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  mpfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mpfb_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_xa          (in_xa),
    .in_ya          (in_ya),
    .in_xb          (in_xb),
    .in_yb          (in_yb),
    .in_ink         (in_ink),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_pixel_value(out_pixel_value),
    .out_clipped    (out_clipped)
  );

  // a byte write always follows the read of the same pixel
  `ASSERT_IMP(a_wr_after_rd, cmd.pix_wr, $past(cmd.pix_rd))
  // no new transaction is taken while the store is being swept
  `ASSERT_IMP(a_no_accept_in_sweep, cmd.clr_step, !in_ready)
  // one command in flight: acceptance closes the input side
  `ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

endmodule

/* design/mpfb_ram.sv */
// ---------------------------------------------------------------------------
// mpfb_ram
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mpfb_ctrl.sv */
// ---------------------------------------------------------------------------
// mpfb_ctrl
// Command sequencer: walks segments, division, pixel read-modify-write, pixel read, sweep.
// ---------------------------------------------------------------------------
module mpfb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_func,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mpfb_pkg::ctl_cmd_t   cmd,
  input  mpfb_pkg::dp_status_t sts
);
  import mpfb_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_LOAD  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_PRD   = 9'b000010000,
    S_PWR   = 9'b000100000,
    S_RREQ  = 9'b001000000,
    S_RDAT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  func_t      func_r, func_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  func_t      in_code;

  assign in_code   = func_t'(in_func);
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    seg_nxt       = seg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.seg       = seg_r;
    cmd.outline   = (func_r == F_OUTLINE);
    cmd.area      = (func_r == F_FILL) || (func_r == F_HATCH);
    cmd.hatch     = (func_r == F_HATCH);
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = (func_r == F_CLEAR) ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          cmd.point   = (in_code == F_PIXEL) || (in_code == F_READ);
          func_nxt    = in_code;
          seg_nxt     = 2'd0;
          unique case (in_code)
            F_CLEAR: begin
              cmd.clr_init = 1'b1;
              state_nxt    = S_CLEAR;
            end
            F_NONE:  state_nxt = S_DONE;
            default: state_nxt = S_LOAD;
          endcase
        end
      end
      S_LOAD: begin
        cmd.seg_load = 1'b1;
        state_nxt    = (cmd.area && sts.empty) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = (func_r == F_READ) ? S_RREQ : S_PRD;
        end
      end
      S_PRD: begin
        cmd.pix_rd = 1'b1;
        state_nxt  = S_PWR;
      end
      S_PWR: begin
        cmd.pix_wr = 1'b1;
        if (sts.seg_last) begin
          if (cmd.outline && seg_r != 2'd3) begin
            seg_nxt   = seg_r + 2'd1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_RREQ: begin
        cmd.pix_rd = 1'b1;
        state_nxt  = S_RDAT;
      end
      S_RDAT: begin
        cmd.rd_dat = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      func_r      <= F_NONE;
      seg_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      func_r      <= func_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/mpfb_dpath.sv */
// ---------------------------------------------------------------------------
// mpfb_dpath
// Coordinates, line and area stepping, page division, pixel location and store.
// ---------------------------------------------------------------------------
module mpfb_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_xa,
  input  logic [7:0]           in_ya,
  input  logic [7:0]           in_xb,
  input  logic [7:0]           in_yb,
  input  logic                 in_ink,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [8:0]           cfg_data,
  input  mpfb_pkg::ctl_cmd_t   cmd,
  output mpfb_pkg::dp_status_t sts,
  output logic                 out_pixel_value,
  output logic                 out_clipped
);
  import mpfb_pkg::*;

  logic [7:0] xa_r, ya_r, xb_r, yb_r;
  logic       ink_r;
  logic [8:0] width_r;
  logic [6:0] height_r;
  logic [3:0] rpb_r;
  logic [8:0] w_eff;
  logic [6:0] h_eff;
  logic [3:0] r_eff;

  logic [7:0] sx0, sy0, sx1, sy1, lx0, ly0, lx1, ly1, ddx, ddy;
  logic [7:0] x_r, y_r, x0_r, x1_r, y1_r, dmaj_r, dmin_r, k_r, rem_r, pg_r;
  logic       xmaj_r;
  logic [3:0] sub_r;
  logic [2:0] dcnt_r;
  logic [HCNT_W-1:0] hcnt_r, hcnt_nxt;

  logic              inside_r, val_r, clip_r, pix_r;
  logic [2:0]        bitpos_r;
  logic [ADDR_W-1:0] waddr_r, clr_addr_r;
  logic              out_pix_r, out_clip_r;

  logic [4:0]        dv_t, dv_sub;
  logic              dv_ge;
  logic [14:0]       prod;
  logic [LOC_W-1:0]  loc;
  logic              on_disp;
  logic [8:0]        rem_sum, x_inc;
  logic              stepm, row_end;
  logic [7:0]        rem_nxt;
  logic              pv;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // register values are saturated into their legal ranges
  always_comb begin
    w_eff = (width_r == 9'd0) ? 9'd1 : ((width_r > 9'd256) ? 9'd256 : width_r);
    h_eff = (height_r == 7'd0) ? 7'd1 : ((height_r > 7'd64) ? 7'd64 : height_r);
    r_eff = (rpb_r == 4'd0) ? 4'd1 : ((rpb_r > 4'd8) ? 4'd8 : rpb_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd128;
      height_r <= 7'd64;
      rpb_r    <= 4'd8;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data[6:0];
        REG_RPB:    rpb_r    <= cfg_data[3:0];
        default:    ;
      endcase
    end
  end

  // outline edges in order: x = xa, y = yb, x = xb, y = ya
  always_comb begin
    if (!cmd.outline) begin
      {sx0, sy0, sx1, sy1} = {xa_r, ya_r, xb_r, yb_r};
    end else begin
      unique case (cmd.seg)
        2'd0:    {sx0, sy0, sx1, sy1} = {xa_r, ya_r, xa_r, yb_r};
        2'd1:    {sx0, sy0, sx1, sy1} = {xa_r, yb_r, xb_r, yb_r};
        2'd2:    {sx0, sy0, sx1, sy1} = {xb_r, ya_r, xb_r, yb_r};
        default: {sx0, sy0, sx1, sy1} = {xa_r, ya_r, xb_r, ya_r};
      endcase
    end
    lx0 = (sx1 < sx0) ? sx1 : sx0;
    lx1 = (sx1 < sx0) ? sx0 : sx1;
    ly0 = (sy1 < sy0) ? sy1 : sy0;
    ly1 = (sy1 < sy0) ? sy0 : sy1;
    ddx = lx1 - lx0;
    ddy = ly1 - ly0;
  end

  // one restoring division step: page and row within the byte
  assign dv_t   = {sub_r, pg_r[7]};
  assign dv_ge  = dv_t >= {1'b0, r_eff};
  assign dv_sub = dv_t - {1'b0, r_eff};

  assign prod    = 15'(pg_r[5:0]) * 15'(w_eff);
  assign loc     = LOC_W'(prod) + LOC_W'(x_r);
  assign on_disp = ({1'b0, x_r} < w_eff) && (y_r < {1'b0, h_eff})
                   && (loc < LOC_W'(BUFFER_BYTES));

  always_comb begin
    hcnt_nxt = (hcnt_r == HCNT_W'(HATCH_PERIOD - 1)) ? '0 : hcnt_r + 1'b1;
    pv       = cmd.hatch ? (hcnt_nxt == '0) : ink_r;
    rem_sum  = {1'b0, rem_r} + {1'b0, dmin_r};
    stepm    = rem_sum >= {1'b0, dmaj_r};
    rem_nxt  = stepm ? 8'(rem_sum - {1'b0, dmaj_r}) : rem_sum[7:0];
    x_inc    = {1'b0, x_r} + 9'd1;
    row_end  = (x_inc == {1'b0, x1_r});
    sts.empty    = (ddx == 8'd0) || (ddy == 8'd0);
    sts.div_done = (dcnt_r == 3'd7);
    sts.seg_last = cmd.area ? (row_end && ({1'b0, y_r} + 9'd1 == {1'b0, y1_r}))
                            : (k_r == dmaj_r);
    sts.clr_last = (clr_addr_r == ADDR_W'(BUFFER_BYTES - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xa_r   <= in_xa;
      ya_r   <= in_ya;
      xb_r   <= cmd.point ? in_xa : in_xb;
      yb_r   <= cmd.point ? in_ya : in_yb;
      ink_r  <= in_ink;
      clip_r <= 1'b0;
      pix_r  <= 1'b0;
      hcnt_r <= '0;
    end
    if (cmd.seg_load) begin
      x_r    <= lx0;
      y_r    <= ly0;
      x0_r   <= lx0;
      x1_r   <= lx1;
      y1_r   <= ly1;
      xmaj_r <= ddx > ddy;
      dmaj_r <= (ddx > ddy) ? ddx : ddy;
      dmin_r <= (ddx > ddy) ? ddy : ddx;
      k_r    <= 8'd0;
      rem_r  <= 8'd0;
      pg_r   <= ly0;
      sub_r  <= 4'd0;
      dcnt_r <= 3'd0;
    end
    if (cmd.div_step) begin
      sub_r  <= dv_ge ? dv_sub[3:0] : dv_t[3:0];
      pg_r   <= {pg_r[6:0], dv_ge};
      dcnt_r <= dcnt_r + 3'd1;
    end
    if (cmd.pix_rd) begin
      inside_r <= on_disp;
      waddr_r  <= loc[ADDR_W-1:0];
      bitpos_r <= sub_r[2:0];
      val_r    <= pv;
      clip_r   <= clip_r | !on_disp;
      if (cmd.hatch) begin
        hcnt_r <= hcnt_nxt;
      end
    end
    if (cmd.pix_wr && !sts.seg_last) begin
      logic yinc;
      yinc = 1'b0;
      if (cmd.area) begin
        if (row_end) begin
          x_r  <= x0_r;
          yinc = 1'b1;
        end else begin
          x_r <= x_inc[7:0];
        end
      end else begin
        k_r   <= k_r + 8'd1;
        rem_r <= rem_nxt;
        if (xmaj_r) begin
          x_r  <= x_inc[7:0];
          yinc = stepm;
        end else begin
          yinc = 1'b1;
          if (stepm) begin
            x_r <= x_inc[7:0];
          end
        end
      end
      if (yinc) begin
        y_r <= y_r + 8'd1;
        if (sub_r + 4'd1 == r_eff) begin
          sub_r <= 4'd0;
          pg_r  <= pg_r + 8'd1;
        end else begin
          sub_r <= sub_r + 4'd1;
        end
      end
    end
    if (cmd.rd_dat) begin
      pix_r <= inside_r && ram_rdata[bitpos_r];
    end
    if (cmd.out_load) begin
      out_pix_r  <= pix_r;
      out_clip_r <= clip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_init) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_comb begin
    ram_wdata = ram_rdata;
    ram_wdata[bitpos_r] = val_r;
    if (cmd.clr_step) begin
      ram_wdata = 8'd0;
    end
    ram_we    = cmd.clr_step || (cmd.pix_wr && inside_r);
    ram_waddr = cmd.clr_step ? clr_addr_r : waddr_r;
  end

  mpfb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(loc[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  assign out_pixel_value = out_pix_r;
  assign out_clipped     = out_clip_r;

endmodule
